// ===== design/dmvm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the dense matrix-vector multiply block.
// Depends on nothing; every other design file refers to it by scoped names.
package dmvm_pkg;

  localparam int unsigned MAX_COLS    = 256;
  localparam int unsigned MAX_ROWS    = 4096;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned SUM_W       = 64;
  localparam int unsigned VIDX_W      = 8;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned ROWCFG_W    = 13;
  localparam int unsigned COLCFG_W    = 9;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = 2;
  localparam int unsigned FIFO_CNT_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_VEC_WRITE  = 1'b0,
    OP_MAT_STREAM = 1'b1
  } op_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [SUM_W-1:0] row_sum;
    logic                    saturated;
    logic                    last_row;
  } result_t;

endpackage

// ===== design/dmvm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and row results.
// Depends on dmvm_pkg for field widths.
interface dmvm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [dmvm_pkg::VIDX_W-1:0]         vector_index;
  logic signed [dmvm_pkg::VALUE_W-1:0] value;

  modport source (output valid, output operation, output vector_index, output value,
                  input ready);
  modport sink   (input valid, input operation, input vector_index, input value,
                  output ready);
endinterface

interface dmvm_out_if;
  logic                              valid;
  logic                              ready;
  logic [dmvm_pkg::ROW_W-1:0]        row_index;
  logic signed [dmvm_pkg::SUM_W-1:0] row_sum;
  logic                              saturated;
  logic                              last_row;

  modport source (output valid, output row_index, output row_sum, output saturated,
                  output last_row, input ready);
  modport sink   (input valid, input row_index, input row_sum, input saturated,
                  input last_row, output ready);
endinterface

// ===== design/dmvm_result_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue between the accumulator and the output channel.
// Depends on dmvm_pkg for the result type and depth constants.
module dmvm_result_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  dmvm_pkg::result_t                   push_data,
  input  logic                                pop,
  output logic                                not_empty,
  output dmvm_pkg::result_t                   head,
  output logic [dmvm_pkg::FIFO_CNT_W-1:0]     count
);

  dmvm_pkg::result_t                  entry_r [dmvm_pkg::FIFO_DEPTH];
  logic [dmvm_pkg::FIFO_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [dmvm_pkg::FIFO_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [dmvm_pkg::FIFO_CNT_W-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{(dmvm_pkg::FIFO_CNT_W-1){1'b0}}, push}
                         - {{(dmvm_pkg::FIFO_CNT_W-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign count     = count_r;

endmodule

// ===== design/dense_matrix_vector_multiply.sv =====
`timescale 1ns / 1ps
// Dense matrix-vector multiply: vector store, multiply pipeline, saturating accumulator.
// Depends on dmvm_pkg, dmvm_if and dmvm_result_fifo.
//
// Usage:
//   Load the vector first: beats with operation = 0 write value into the vector
//   store at vector_index; an index at or beyond the column count is dropped.
//   Then stream matrix elements in row-major order with operation = 1. After
//   the last column of a row, one result beat carries the row index, the
//   saturated Q16.48 row sum, a clip flag and, on the final row, last_row.
//   Throughput: one beat per cycle on the input, vector writes and matrix
//   elements alike, while input ready is high. A row result passes the store
//   read, the registered product and the accumulate into the result queue.
//   Output stall: results collect in a four-entry queue; input ready drops only
//   when the queue plus the row results still in the pipeline could fill it.
//   Reset clears positions, sum and configuration (one row, one column); the
//   vector store keeps no reset value and must be written before it is read.
//   A configuration write restarts the stream at row 0, column 0.
module dense_matrix_vector_multiply (
  input  logic                              clk,
  input  logic                              rst_n,
  dmvm_in_if.sink                           in_ch,
  dmvm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [dmvm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmvm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned COL_POS_W = $clog2(dmvm_pkg::MAX_COLS);

  // Effective limits, stored as count minus one.
  logic [COL_POS_W-1:0]           cols_m1_r;
  logic [dmvm_pkg::ROW_W-1:0]     rows_m1_r;

  // Stream position.
  logic [COL_POS_W-1:0]           col_pos_r, col_pos_nxt;
  logic [dmvm_pkg::ROW_W-1:0]     row_pos_r, row_pos_nxt;

  // Vector store.
  logic [dmvm_pkg::VALUE_W-1:0]   vec_mem [dmvm_pkg::MAX_COLS];
  logic [dmvm_pkg::VALUE_W-1:0]   vec_rd_r;

  // Stage 1: operand registers alongside the store read.
  logic                           v1_r, eor1_r, last1_r;
  logic [dmvm_pkg::ROW_W-1:0]     row1_r;
  logic signed [dmvm_pkg::VALUE_W-1:0] mat1_r;

  // Stage 2: registered product.
  logic                           v2_r, eor2_r, last2_r;
  logic [dmvm_pkg::ROW_W-1:0]     row2_r;
  logic signed [dmvm_pkg::SUM_W-1:0] prod2_r, prod_nxt;

  // Accumulator.
  logic signed [dmvm_pkg::SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic                           clip_r, clip_nxt;
  logic                           ovf;

  logic                           in_accept, mat_beat, vec_beat;
  logic                           eor_now, last_now;
  logic                           fifo_valid;
  logic [dmvm_pkg::FIFO_CNT_W-1:0] fifo_count, pending;
  dmvm_pkg::result_t              fifo_head, res_push;
  logic                           res_push_en;

  logic [dmvm_pkg::COLCFG_W-1:0]  cfg_cols;
  logic [dmvm_pkg::ROWCFG_W-1:0]  cfg_rows;

  // Hold the input whenever the row results already on their way could
  // fill the queue.
  always_comb begin
    pending = fifo_count
            + {{(dmvm_pkg::FIFO_CNT_W-1){1'b0}}, v1_r & eor1_r}
            + {{(dmvm_pkg::FIFO_CNT_W-1){1'b0}}, v2_r & eor2_r};
  end
  assign in_ch.ready = (pending < dmvm_pkg::FIFO_CNT_W'(dmvm_pkg::FIFO_DEPTH));

  assign in_accept = in_ch.valid && in_ch.ready;
  assign mat_beat  = in_accept && (in_ch.operation == dmvm_pkg::OP_MAT_STREAM);
  assign vec_beat  = in_accept && (in_ch.operation == dmvm_pkg::OP_VEC_WRITE);

  assign eor_now  = (col_pos_r == cols_m1_r);
  assign last_now = (row_pos_r == rows_m1_r);

  // Advance column, then row, wrapping at the end of the matrix.
  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (mat_beat) begin
      if (eor_now) begin
        col_pos_nxt = '0;
        row_pos_nxt = last_now ? '0 : row_pos_r + 1'b1;
      end else begin
        col_pos_nxt = col_pos_r + 1'b1;
      end
    end
  end

  // Slice configuration fields from cfg_data: the column count keeps its low nine bits, the row count all thirteen.
  always_comb begin
    cfg_cols = cfg_data[dmvm_pkg::COLCFG_W-1:0];
    cfg_rows = cfg_data[dmvm_pkg::ROWCFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_m1_r <= '0;
      rows_m1_r <= '0;
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (cfg_we) begin
      unique case (dmvm_pkg::cfg_reg_t'(cfg_index))
        dmvm_pkg::CFG_ROW_COUNT: begin
          if (cfg_rows == '0) begin
            rows_m1_r <= '0;
          end else if (cfg_rows > dmvm_pkg::ROWCFG_W'(dmvm_pkg::MAX_ROWS)) begin
            rows_m1_r <= dmvm_pkg::ROW_W'(dmvm_pkg::MAX_ROWS - 1);
          end else begin
            rows_m1_r <= dmvm_pkg::ROW_W'(cfg_rows - 1'b1);
          end
        end
        dmvm_pkg::CFG_COL_COUNT: begin
          if (cfg_cols == '0) begin
            cols_m1_r <= '0;
          end else if (cfg_cols > dmvm_pkg::COLCFG_W'(dmvm_pkg::MAX_COLS)) begin
            cols_m1_r <= COL_POS_W'(dmvm_pkg::MAX_COLS - 1);
          end else begin
            cols_m1_r <= COL_POS_W'(cfg_cols - 1'b1);
          end
        end
        default: begin
        end
      endcase
      // Restart the stream on any write.
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

  // Vector store: write on vector beats within range, read the current column
  // every cycle. A write lands before any later beat reads it.
  always_ff @(posedge clk) begin
    if (vec_beat && (in_ch.vector_index <= cols_m1_r)) begin
      vec_mem[in_ch.vector_index] <= in_ch.value;
    end
    vec_rd_r <= vec_mem[col_pos_r];
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= mat_beat;
      v2_r <= v1_r;
    end
  end

  // Pipeline payload.
  assign prod_nxt = $signed(vec_rd_r) * mat1_r;

  always_ff @(posedge clk) begin
    eor1_r  <= eor_now;
    last1_r <= last_now;
    row1_r  <= row_pos_r;
    mat1_r  <= in_ch.value;
    eor2_r  <= eor1_r;
    last2_r <= last1_r;
    row2_r  <= row1_r;
    prod2_r <= prod_nxt;
  end

  // Saturating accumulate: clip when both operands share a sign the sum lost.
  always_comb begin
    sum_add = sum_r + prod2_r;
    ovf     = (sum_r[dmvm_pkg::SUM_W-1] == prod2_r[dmvm_pkg::SUM_W-1])
           && (sum_add[dmvm_pkg::SUM_W-1] != sum_r[dmvm_pkg::SUM_W-1]);
    if (ovf) begin
      sum_nxt = sum_r[dmvm_pkg::SUM_W-1] ? {1'b1, {(dmvm_pkg::SUM_W-1){1'b0}}}
                                         : {1'b0, {(dmvm_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_nxt = sum_add;
    end
    clip_nxt = clip_r | ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      clip_r <= 1'b0;
    end else if (cfg_we) begin
      sum_r  <= '0;
      clip_r <= 1'b0;
    end else if (v2_r) begin
      if (eor2_r) begin
        sum_r  <= '0;
        clip_r <= 1'b0;
      end else begin
        sum_r  <= sum_nxt;
        clip_r <= clip_nxt;
      end
    end
  end

  always_comb begin
    res_push_en         = v2_r && eor2_r;
    res_push.row_index  = row2_r;
    res_push.row_sum    = sum_nxt;
    res_push.saturated  = clip_nxt;
    res_push.last_row   = last2_r;
  end

  dmvm_result_fifo u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push_en),
    .push_data (res_push),
    .pop       (out_ch.valid && out_ch.ready),
    .not_empty (fifo_valid),
    .head      (fifo_head),
    .count     (fifo_count)
  );

  assign out_ch.valid     = fifo_valid;
  assign out_ch.row_index = fifo_head.row_index;
  assign out_ch.row_sum   = fifo_head.row_sum;
  assign out_ch.saturated = fifo_head.saturated;
  assign out_ch.last_row  = fifo_head.last_row;

endmodule
